>>> rtl/core/mp_pkg.sv
// ----------------------------------------------------------------------------
// mp_pkg: shared types and constants of the 2x2 max pooling stream
// Register indexes, configuration field widths and the control word that the
// scan counter hands to the datapath.
// ----------------------------------------------------------------------------
package mp_pkg;

  localparam int IMG_SIZE_W  = 9;
  localparam int CHAN_CNT_W  = 11;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd1;

  // What the accepted sample does to the window logic.
  typedef struct packed {
    logic store_left;   // even column: keep as left sample
    logic store_upper;  // odd column of an upper row: write pair maximum
    logic emit;         // odd column of a lower row: produce a result
    logic plane_end;
    logic map_end;
  } scan_t;

endpackage

>>> rtl/core/mp_in_if.sv
// ----------------------------------------------------------------------------
// mp_in_if: sample input channel
// Valid/ready channel carrying one signed sample per transfer.
// ----------------------------------------------------------------------------
interface mp_in_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/core/mp_out_if.sv
// ----------------------------------------------------------------------------
// mp_out_if: pooled result channel
// Valid/ready channel carrying one window maximum and its end markers.
// ----------------------------------------------------------------------------
interface mp_out_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] pooled_value;
  logic         last_in_plane;
  logic         last_in_map;

  modport source (output valid, output pooled_value, output last_in_plane,
                  output last_in_map, input ready);
  modport sink   (input valid, input pooled_value, input last_in_plane,
                  input last_in_map, output ready);
endinterface

>>> rtl/core/mp_cfg_if.sv
// ----------------------------------------------------------------------------
// mp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ----------------------------------------------------------------------------
interface mp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mp_pkg::CFG_IDX_W-1:0]  index;
  logic [mp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mp_ram.sv
// ----------------------------------------------------------------------------
// mp_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module mp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mp_scan.sv
// ----------------------------------------------------------------------------
// mp_scan: configuration registers and raster position counters
// Tracks column, row and plane of the next sample and classifies each
// accepted sample for the window datapath.
// ----------------------------------------------------------------------------
module mp_scan #(
  parameter int MAX_SIZE     = 256,
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write,
  input  logic [mp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          step,
  output mp_pkg::scan_t                 ctl,
  output logic [((MAX_SIZE/2 > 1) ? $clog2(MAX_SIZE/2) : 1)-1:0] slot
);

  localparam int CNT_W  = $clog2(MAX_SIZE);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W = (MAX_SIZE/2 > 1) ? $clog2(MAX_SIZE/2) : 1;

  logic [CNT_W-1:0] n_m1_r, half_m1_r;
  logic             odd_r;
  logic [CH_W-1:0]  ch_m1_r;
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;

  int               size_eff, chan_eff;
  logic [CNT_W-1:0] n_m1_cfg, half_m1_cfg;
  logic             odd_cfg;
  logic [CH_W-1:0]  ch_m1_cfg;
  logic             wr_size, wr_chan;
  logic             in_window;

  // Out-of-range sizes and counts are clamped once, when written.
  always_comb begin
    size_eff = int'(cfg_data[mp_pkg::IMG_SIZE_W-1:0]);
    if (size_eff < 2) begin
      size_eff = 2;
    end else if (size_eff > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end
    chan_eff = int'(cfg_data[mp_pkg::CHAN_CNT_W-1:0]);
    if (chan_eff < 1) begin
      chan_eff = 1;
    end else if (chan_eff > MAX_CHANNELS) begin
      chan_eff = MAX_CHANNELS;
    end
    n_m1_cfg    = CNT_W'(size_eff - 1);
    half_m1_cfg = CNT_W'((size_eff >> 1) - 1);
    odd_cfg     = size_eff[0];
    ch_m1_cfg   = CH_W'(chan_eff - 1);
  end

  always_comb begin
    wr_size = 1'b0;
    wr_chan = 1'b0;
    unique case (cfg_index)
      mp_pkg::REG_IMAGE_SIZE:    wr_size = cfg_write;
      mp_pkg::REG_CHANNEL_COUNT: wr_chan = cfg_write;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_m1_r    <= CNT_W'(1);
      half_m1_r <= '0;
      odd_r     <= 1'b0;
      ch_m1_r   <= '0;
    end else begin
      if (wr_size) begin
        n_m1_r    <= n_m1_cfg;
        half_m1_r <= half_m1_cfg;
        odd_r     <= odd_cfg;
      end
      if (wr_chan) begin
        ch_m1_r <= ch_m1_cfg;
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ch_nxt  = ch_r;
    if (wr_size || wr_chan) begin
      col_nxt = '0;
      row_nxt = '0;
      ch_nxt  = '0;
    end else if (step) begin
      col_nxt = col_r + CNT_W'(1);
      if (col_r == n_m1_r) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
        if (row_r == n_m1_r) begin
          row_nxt = '0;
          ch_nxt  = (ch_r == ch_m1_r) ? '0 : ch_r + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // On an odd size the last column and the last row fall outside every window.
  assign in_window = !(odd_r && ((col_r == n_m1_r) || (row_r == n_m1_r)));

  always_comb begin
    ctl.store_left  = in_window && !col_r[0];
    ctl.store_upper = in_window && col_r[0] && !row_r[0];
    ctl.emit        = in_window && col_r[0] && row_r[0];
    ctl.plane_end   = ((col_r >> 1) == half_m1_r) && ((row_r >> 1) == half_m1_r);
    ctl.map_end     = ctl.plane_end && (ch_r == ch_m1_r);
  end

  assign slot = SLOT_W'(col_r >> 1);

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= n_m1_r) && (row_r <= n_m1_r))
    else $error("position counter beyond the plane size");

  a_map_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_write && (col_r == n_m1_r) && (row_r == n_m1_r) && (ch_r == ch_m1_r))
    |=> (col_r == '0) && (row_r == '0) && (ch_r == '0))
    else $error("counters did not wrap at the end of the map");

endmodule

>>> rtl/core/mp_reduce.sv
// ----------------------------------------------------------------------------
// mp_reduce: window maximum datapath
// Holds the left sample, keeps upper-row pair maxima in the line store and
// combines them with the lower-row pair through a read stage and an output
// register.
// ----------------------------------------------------------------------------
module mp_reduce #(
  parameter int W      = 16,
  parameter int DEPTH  = 128,
  parameter int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [W-1:0]      in_sample,
  output logic              in_ready,
  output logic              step,
  input  mp_pkg::scan_t     ctl,
  input  logic [SLOT_W-1:0] slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [W-1:0]      out_value,
  output logic              out_plane,
  output logic              out_map
);

  logic signed [W-1:0] x, left_r, pair;
  logic                ram_we, ram_re;
  logic [W-1:0]        ram_rdata;
  logic signed [W-1:0] upper;

  logic                b_valid_r, b_valid_nxt, b_adv;
  logic signed [W-1:0] b_pair_r;
  logic                b_plane_r, b_map_r;

  logic                out_valid_r;
  logic [W-1:0]        out_value_r;
  logic                out_plane_r, out_map_r;

  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_adv;
  assign step     = in_valid && in_ready;

  assign x    = $signed(in_sample);
  assign pair = (x > left_r) ? x : left_r;

  always_ff @(posedge clk) begin
    if (step && ctl.store_left) begin
      left_r <= x;
    end
  end

  // Writes happen only in upper rows and reads only in lower rows, so one
  // cycle never reads and writes the same entry.
  assign ram_we = step && ctl.store_upper;
  assign ram_re = step && ctl.emit;

  mp_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH),
    .AW    (SLOT_W)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (pair),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign upper = $signed(ram_rdata);

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (ram_re) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      b_pair_r  <= pair;
      b_plane_r <= ctl.plane_end;
      b_map_r   <= ctl.map_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_value_r <= (upper > b_pair_r) ? upper : b_pair_r;
      out_plane_r <= b_plane_r;
      out_map_r   <= b_map_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_plane = out_plane_r;
  assign out_map   = out_map_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store read and written in the same cycle");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ctl.emit) |=> b_valid_r)
    else $error("lower-right sample did not load the read stage");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> (b_valid_r && $stable(b_pair_r) && !$past(step)))
    else $error("read stage lost or changed its pair while stalled");

endmodule

>>> rtl/core/max_pool_2x2_stream_top.sv
// ----------------------------------------------------------------------------
// max_pool_2x2_stream_top: 2x2 stride-2 max pooling over a sample stream
// Samples arrive on in_ch in raster order, one channel plane after another.
// Each transfer on out_ch carries the maximum of one 2x2 window together with
// end-of-plane and end-of-map markers. On an odd image size the last row and
// column of each plane are skipped.
// cfg_ch writes image_size (index 0) and channel_count (index 1); it is always
// ready. A valid write to either register restarts the position counters at a
// new map, and writes should be made only while no results are outstanding.
// Throughput is one sample per cycle while out_ch keeps up; the line store
// takes at most one write or one read per sample. A result passes from the
// lower-right sample of its window through the line store read into the read
// stage, then through the compare into the output register.
// A stalled receiver first fills the output register, then the read stage;
// in_ch.ready drops only when both are occupied.
// Reset sets the image size to 2 and the channel count to 1 and clears the
// counters and pipeline valids. The line store is not cleared: every entry is
// written in an upper row before the lower row reads it.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream_top #(
  parameter int MAX_SIZE     = 256,
  parameter int MAX_CHANNELS = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mp_in_if.sink     in_ch,
  mp_out_if.source  out_ch,
  mp_cfg_if.sink    cfg_ch
);

  localparam int DEPTH  = MAX_SIZE / 2;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mp_pkg::scan_t     ctl;
  logic [SLOT_W-1:0] slot;
  logic              step;
  logic              cfg_write;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid;

  mp_scan #(
    .MAX_SIZE     (MAX_SIZE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .step      (step),
    .ctl       (ctl),
    .slot      (slot)
  );

  mp_reduce #(
    .W      (SAMPLE_WIDTH),
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.sample),
    .in_ready  (in_ch.ready),
    .step      (step),
    .ctl       (ctl),
    .slot      (slot),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.pooled_value),
    .out_plane (out_ch.last_in_plane),
    .out_map   (out_ch.last_in_map)
  );

endmodule
